// ----- rtl/drs_pkg.sv -----
// Shared codes and controller/datapath interface types of the disk request scheduler.
`default_nettype none
package drs_pkg;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_GRANTED = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [2:0] POL_FIFO  = 3'd0;
  localparam logic [2:0] POL_SSTF  = 3'd1;
  localparam logic [2:0] POL_LOOK  = 3'd2;
  localparam logic [2:0] POL_CLOOK = 3'd3;
  localparam logic [2:0] POL_FLOOK = 3'd4;

  typedef struct packed {
    logic accept;
    logic add;
    logic prep;
    logic none;
    logic scan_start;
    logic scan;
    logic pick;
    logic shift;
    logic dec;
    logic done;
  } drs_cmd_t;

  typedef struct packed {
    logic in_sel;
    logic act_empty;
    logic scan_last;
    logic shift_last;
    logic out_free;
  } drs_stat_t;

endpackage
`default_nettype wire

// ----- rtl/drs_ctrl.sv -----
// Sequencer of the disk request scheduler: add, scan, pick, compaction, result.
`default_nettype none
module drs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  drs_pkg::drs_stat_t     stat_i,
  output drs_pkg::drs_cmd_t      cmd_o
);
  import drs_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADD    = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_DRAIN  = 4'd5;
  localparam logic [3:0] S_PICK   = 4'd6;
  localparam logic [3:0] S_SHIFT  = 4'd7;
  localparam logic [3:0] S_SHEND  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = stat_i.in_sel ? S_PREP : S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d = S_DONE;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.act_empty) begin
          cmd_o.none = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_PICK;
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        // move later entries down one slot, one per cycle
        if (stat_i.shift_last) state_d = S_SHEND;
        else cmd_o.shift = 1'b1;
      end
      S_SHEND: begin
        cmd_o.dec = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.done = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule
`default_nettype wire

// ----- rtl/drs_dp.sv -----
// Datapath of the disk request scheduler: queue memory, candidate scan, head state, result.
`default_nettype none
module drs_dp #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TRACK_BITS  = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_wdata_i,
  input  wire logic              cmd_i,
  input  wire logic [15:0]       track_i,
  input  wire logic [15:0]       req_tag_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             status_o,
  output logic [15:0]            granted_tag_o,
  output logic [15:0]            granted_track_o,
  output logic [15:0]            seek_distance_o,
  output logic                   sweep_backward_o,
  input  drs_pkg::drs_cmd_t      ctl_cmd_i,
  output drs_pkg::drs_stat_t     stat_o
);
  import drs_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TB = TRACK_BITS;
  localparam int EW = TB + 16;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  localparam int C_FIFO = 0;
  localparam int C_SSTF = 1;
  localparam int C_FWD  = 2;
  localparam int C_BWD  = 3;
  localparam int C_FAR  = 4;
  localparam int NC     = 5;

  // two banks: pending lives in bank psel_q, the frozen batch in the other
  logic [EW-1:0] mem [2*QUEUE_DEPTH];
  logic [EW-1:0] rd_q;

  logic [2:0]    policy_q;
  logic [TB-1:0] req_trk_q;
  logic [15:0]   req_tag_q;
  logic          psel_q;
  logic [CW-1:0] pcnt_q, bcnt_q;
  logic [TB-1:0] head_q;
  logic          back_q;
  logic [CW-1:0] addr_q;
  logic          rd_vld_q;
  logic [IW-1:0] rd_idx_q;
  logic          wb_vld_q;
  logic [IW-1:0] wb_dst_q;

  logic          cand_v_q   [NC];
  logic [IW-1:0] cand_idx_q [NC];
  logic [TB-1:0] cand_d_q   [NC];
  logic [TB-1:0] cand_trk_q [NC];
  logic [15:0]   cand_tag_q [NC];

  logic [1:0]    res_st_q;
  logic [15:0]   res_tag_q;
  logic [TB-1:0] res_trk_q, res_seek_q;

  logic          out_valid_q;
  logic [1:0]    out_st_q;
  logic [15:0]   out_tag_q, out_trk_q, out_seek_q;
  logic          out_back_q;

  logic          flook;
  logic          act_bank;
  logic [CW-1:0] act_cnt;
  logic [TB-1:0] rd_trk, rd_dist;
  logic [15:0]   rd_tag;
  logic [2:0]    sel;
  logic          new_back;
  logic [TB-1:0] p_trk, p_seek;

  assign flook    = (policy_q == POL_FLOOK);
  assign act_bank = flook ? ~psel_q : psel_q;
  assign act_cnt  = flook ? bcnt_q : pcnt_q;

  assign rd_trk  = rd_q[TB-1:0];
  assign rd_tag  = rd_q[EW-1:TB];
  assign rd_dist = (rd_trk >= head_q) ? rd_trk - head_q : head_q - rd_trk;

  assign stat_o.in_sel     = (cmd_i == CMD_SELECT);
  assign stat_o.act_empty  = (act_cnt == '0);
  assign stat_o.scan_last  = (addr_q == act_cnt - CW'(1));
  assign stat_o.shift_last = (addr_q >= act_cnt);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    sel      = 3'(C_FIFO);
    new_back = back_q;
    case (policy_q)
      POL_SSTF:  sel = 3'(C_SSTF);
      POL_CLOOK: sel = cand_v_q[C_FWD] ? 3'(C_FWD) : 3'(C_FAR);
      POL_LOOK, POL_FLOOK: begin
        // reverse when nothing lies ahead
        if (back_q) begin
          if (cand_v_q[C_BWD]) sel = 3'(C_BWD);
          else begin
            sel = 3'(C_FWD);
            new_back = 1'b0;
          end
        end else begin
          if (cand_v_q[C_FWD]) sel = 3'(C_FWD);
          else begin
            sel = 3'(C_BWD);
            new_back = 1'b1;
          end
        end
      end
      default: sel = 3'(C_FIFO);
    endcase
  end

  assign p_trk  = cand_trk_q[sel];
  assign p_seek = (p_trk >= head_q) ? p_trk - head_q : head_q - p_trk;

  // queue memory
  always_ff @(posedge clk_i) begin
    if (ctl_cmd_i.add && pcnt_q != DEPTH_C)
      mem[{psel_q, pcnt_q[IW-1:0]}] <= {req_tag_q, req_trk_q};
    else if (wb_vld_q)
      mem[{act_bank, wb_dst_q}] <= rd_q;
    if (ctl_cmd_i.scan || ctl_cmd_i.shift)
      rd_q <= mem[{act_bank, addr_q[IW-1:0]}];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_cmd_i.accept) begin
      req_trk_q <= TB'(track_i);
      req_tag_q <= req_tag_i;
    end
    rd_idx_q <= addr_q[IW-1:0];
    wb_dst_q <= addr_q[IW-1:0] - IW'(1);
    if (rd_vld_q) begin
      if (rd_idx_q == '0) begin
        cand_trk_q[C_FIFO] <= rd_trk;
        cand_tag_q[C_FIFO] <= rd_tag;
        cand_idx_q[C_FIFO] <= '0;
      end
      if (!cand_v_q[C_SSTF] || rd_dist < cand_d_q[C_SSTF]) begin
        cand_d_q[C_SSTF]   <= rd_dist;
        cand_trk_q[C_SSTF] <= rd_trk;
        cand_tag_q[C_SSTF] <= rd_tag;
        cand_idx_q[C_SSTF] <= rd_idx_q;
      end
      if (rd_trk >= head_q && (!cand_v_q[C_FWD] || rd_dist < cand_d_q[C_FWD])) begin
        cand_d_q[C_FWD]   <= rd_dist;
        cand_trk_q[C_FWD] <= rd_trk;
        cand_tag_q[C_FWD] <= rd_tag;
        cand_idx_q[C_FWD] <= rd_idx_q;
      end
      if (rd_trk <= head_q && (!cand_v_q[C_BWD] || rd_dist < cand_d_q[C_BWD])) begin
        cand_d_q[C_BWD]   <= rd_dist;
        cand_trk_q[C_BWD] <= rd_trk;
        cand_tag_q[C_BWD] <= rd_tag;
        cand_idx_q[C_BWD] <= rd_idx_q;
      end
      // farthest from the head; only used when every entry lies below the head
      if (!cand_v_q[C_FAR] || rd_dist > cand_d_q[C_FAR]) begin
        cand_d_q[C_FAR]   <= rd_dist;
        cand_trk_q[C_FAR] <= rd_trk;
        cand_tag_q[C_FAR] <= rd_tag;
        cand_idx_q[C_FAR] <= rd_idx_q;
      end
    end
    if (ctl_cmd_i.add) begin
      res_st_q   <= (pcnt_q == DEPTH_C) ? ST_FULL : ST_ADDED;
      res_tag_q  <= '0;
      res_trk_q  <= '0;
      res_seek_q <= '0;
    end else if (ctl_cmd_i.none) begin
      res_st_q   <= ST_NONE;
      res_tag_q  <= '0;
      res_trk_q  <= '0;
      res_seek_q <= '0;
    end else if (ctl_cmd_i.pick) begin
      res_st_q   <= ST_GRANTED;
      res_tag_q  <= cand_tag_q[sel];
      res_trk_q  <= p_trk;
      res_seek_q <= p_seek;
    end
    if (ctl_cmd_i.done) begin
      out_st_q   <= res_st_q;
      out_tag_q  <= res_tag_q;
      out_trk_q  <= 16'(res_trk_q);
      out_seek_q <= 16'(res_seek_q);
      out_back_q <= back_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= POL_FIFO;
      psel_q      <= 1'b0;
      pcnt_q      <= '0;
      bcnt_q      <= '0;
      head_q      <= '0;
      back_q      <= 1'b0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      wb_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NC; k++) cand_v_q[k] <= 1'b0;
    end else begin
      if (cfg_we_i) policy_q <= cfg_wdata_i;
      rd_vld_q <= ctl_cmd_i.scan;
      wb_vld_q <= ctl_cmd_i.shift;
      if (ctl_cmd_i.add && pcnt_q != DEPTH_C) pcnt_q <= pcnt_q + CW'(1);
      // swap banks instead of copying the pending queue into the batch
      if (ctl_cmd_i.prep && flook && bcnt_q == '0) begin
        psel_q <= ~psel_q;
        bcnt_q <= pcnt_q;
        pcnt_q <= '0;
      end
      if (ctl_cmd_i.scan_start) begin
        addr_q <= '0;
        for (int k = 0; k < NC; k++) cand_v_q[k] <= 1'b0;
      end
      if (ctl_cmd_i.scan || ctl_cmd_i.shift) addr_q <= addr_q + CW'(1);
      if (rd_vld_q) begin
        cand_v_q[C_FIFO] <= 1'b1;
        cand_v_q[C_SSTF] <= 1'b1;
        cand_v_q[C_FAR]  <= 1'b1;
        if (rd_trk >= head_q) cand_v_q[C_FWD] <= 1'b1;
        if (rd_trk <= head_q) cand_v_q[C_BWD] <= 1'b1;
      end
      if (ctl_cmd_i.pick) begin
        head_q <= p_trk;
        if (p_trk > head_q) back_q <= 1'b0;
        else if (p_trk < head_q) back_q <= 1'b1;
        else back_q <= new_back;
        addr_q <= CW'(cand_idx_q[sel]) + CW'(1);
      end
      if (ctl_cmd_i.dec) begin
        if (flook) bcnt_q <= bcnt_q - CW'(1);
        else pcnt_q <= pcnt_q - CW'(1);
      end
      if (ctl_cmd_i.done) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_st_q;
  assign granted_tag_o    = out_tag_q;
  assign granted_track_o  = out_trk_q;
  assign seek_distance_o  = out_seek_q;
  assign sweep_backward_o = out_back_q;

endmodule
`default_nettype wire

// ----- rtl/disk_request_scheduler_unit.sv -----
// Top level of the disk request scheduler: controller plus datapath.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o   | cmd_i, track_i, req_tag_i
//  out     | output    | out_valid_o/out_ready_i | status_o, granted_tag_o, granted_track_o,
//          |           |                         | seek_distance_o, sweep_backward_o
//  cfg     | input     | cfg_we_i                | cfg_wdata_i (policy)
//
// An add and a select on an empty queue finish without a scan. A select that grants
// an entry reads every entry of the served queue once to scan it, then moves each entry
// behind the granted one down a slot to close the gap.
// One item is in work at a time; the result waits in the output register, and a stalled
// output holds the next item before its result is written, so the input stalls too.
// Reset clears counts, head and direction; queue memory is not cleared.
`default_nettype none
module disk_request_scheduler_unit #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TRACK_BITS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [15:0] track_i,
  input  wire logic [15:0] req_tag_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [15:0]      granted_tag_o,
  output logic [15:0]      granted_track_o,
  output logic [15:0]      seek_distance_o,
  output logic             sweep_backward_o
);
  import drs_pkg::*;

  drs_cmd_t  ctl_cmd;
  drs_stat_t dp_stat;

  drs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  drs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TRACK_BITS  (TRACK_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_i            (cmd_i),
    .track_i          (track_i),
    .req_tag_i        (req_tag_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .granted_tag_o    (granted_tag_o),
    .granted_track_o  (granted_track_o),
    .seek_distance_o  (seek_distance_o),
    .sweep_backward_o (sweep_backward_o),
    .ctl_cmd_i        (ctl_cmd),
    .stat_o           (dp_stat)
  );

endmodule
`default_nettype wire
